@@ src/qsbc_pkg.sv @@
// ----------------------------------------------------------------------------
// qsbc_pkg
// Shared types, constants and helpers for the quarter-step box collision unit.
// ----------------------------------------------------------------------------
package qsbc_pkg;

	localparam int MAX_BOXES_DEF = 64;
	localparam int SUB_STEPS     = 4;
	localparam int STEP_SHIFT    = 2;

	localparam int COORD_W = 16;
	localparam int EXT_W   = 15;
	localparam int KIND_W  = 8;
	localparam int SLOT_W  = 6;
	localparam int CNT_W   = 7;
	localparam int SCR_W   = 15;
	localparam int CFG_W   = 15;
	localparam int CIDX_W  = 2;
	localparam int PNT_W   = 20;
	localparam int STEP_W  = 3;
	localparam int OUTC_W  = 2;

	localparam int IN_DATA_W  = 144;
	localparam int OUT_DATA_W = 16;

	localparam logic [SCR_W-1:0] SCREEN_W_RST = 15'd10240;
	localparam logic [SCR_W-1:0] SCREEN_H_RST = 15'd7680;

	typedef enum logic [CIDX_W-1:0] {
		REG_OBJECT_COUNT  = 2'd0,
		REG_SCREEN_WIDTH  = 2'd1,
		REG_SCREEN_HEIGHT = 2'd2,
		REG_UNUSED        = 2'd3
	} reg_idx_t;

	typedef enum logic [OUTC_W-1:0] {
		OUT_NONE = 2'd0,
		OUT_HIT  = 2'd1,
		OUT_OOB  = 2'd2
	} outcome_t;

	typedef enum logic [1:0] {
		RES_EMPTY,
		RES_OOB,
		RES_HIT,
		RES_CLEAR
	} res_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PROBE,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic [EXT_W-1:0]          height;
		logic [EXT_W-1:0]          width;
		logic signed [COORD_W-1:0] bottom;
		logic signed [COORD_W-1:0] left;
	} box_t;

	typedef struct packed {
		logic capture;
		logic load;
		logic step_next;
		logic idx_clr;
		logic idx_inc;
		logic rd_first;
		logic set_res;
		res_t res_sel;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic oob;
		logic hit;
		logic last_box;
		logic last_step;
	} st_t;

	function automatic int idx_width(int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

@@ src/quarter_step_box_collision_unit.sv @@
// ----------------------------------------------------------------------------
// quarter_step_box_collision_unit
// Box table with a four sub-step swept point collision query.
// ----------------------------------------------------------------------------
// Box load: no result word; the next word is taken in the cycle after.
// Query: per sub-step, one probe of the screen limits, then one box test per cycle
// from the table RAM over the N active boxes until a hit or the last box.
// Empty table: goes straight to the done state. Next word in the cycle after the
// result word is loaded; a result word not taken holds the query in the done state.
// Reset clears control and config registers; table contents undefined until loaded.
module quarter_step_box_collision_unit
	import qsbc_pkg::*;
#(
	parameter int MAX_BOXES = MAX_BOXES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CIDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]      cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// slot, box_left, box_bottom, box_width, box_height, box_kind,
	// start_x, start_y, end_x, end_y, zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// mode
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// clear_steps, outcome, hit_kind, zero pad
	output logic [OUT_DATA_W-1:0] m_tdata
);

	cmd_t cmd;
	st_t  st;

	qsbc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.st      (st),
		.cmd     (cmd)
	);

	qsbc_dp #(
		.MAX_BOXES(MAX_BOXES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.st       (st),
		.m_tdata  (m_tdata)
	);

endmodule

@@ src/qsbc_ram.sv @@
// ----------------------------------------------------------------------------
// qsbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qsbc_ram
	import qsbc_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = idx_width(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/qsbc_dp.sv @@
// ----------------------------------------------------------------------------
// qsbc_dp
// Datapath: config registers, box table, sub-step point, box test, result.
// ----------------------------------------------------------------------------
module qsbc_dp
	import qsbc_pkg::*;
#(
	parameter int MAX_BOXES = MAX_BOXES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CIDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]      cfg_wdata,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  cmd_t                  cmd,
	output st_t                   st,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int AW = idx_width(MAX_BOXES);
	localparam int CW = $clog2(MAX_BOXES + 1);
	localparam int XW = (CW > CNT_W) ? CW : CNT_W;

	logic [CNT_W-1:0] count_q;
	logic [SCR_W-1:0] sw_q, sh_q;

	logic signed [PNT_W-1:0] px_q, py_q, dx_q, dy_q;
	logic [STEP_W-1:0]       step_q;
	logic [AW-1:0]           idx_q;

	logic [STEP_W-1:0] res_clear_q;
	outcome_t          res_outcome_q;
	logic [KIND_W-1:0] res_kind_q;
	logic [STEP_W-1:0] out_clear_q;
	outcome_t          out_outcome_q;
	logic [KIND_W-1:0] out_kind_q;

	logic [SLOT_W-1:0]         in_slot;
	box_t                      in_box;
	logic signed [COORD_W-1:0] sx, sy, ex, ey;
	logic signed [PNT_W-1:0]   sx_w, sy_w, ddx, ddy;

	logic [XW-1:0] cnt_ext;
	logic [CW-1:0] eff_count;
	logic          slot_ok;
	logic [AW-1:0] rd_addr;
	box_t          rd_box;

	logic signed [PNT_W-1:0] sw4, sh4;
	logic signed [17:0]      lw, bh;
	logic signed [PNT_W-1:0] x0, x1, y0, y1;

	assign in_slot       = s_tdata[5:0];
	assign in_box.left   = s_tdata[21:6];
	assign in_box.bottom = s_tdata[37:22];
	assign in_box.width  = s_tdata[52:38];
	assign in_box.height = s_tdata[67:53];
	assign in_box.kind   = s_tdata[75:68];
	assign sx            = s_tdata[91:76];
	assign sy            = s_tdata[107:92];
	assign ex            = s_tdata[123:108];
	assign ey            = s_tdata[139:124];

	assign sx_w = PNT_W'(sx);
	assign sy_w = PNT_W'(sy);
	assign ddx  = PNT_W'(ex) - sx_w;
	assign ddy  = PNT_W'(ey) - sy_w;

	assign cnt_ext   = XW'(count_q);
	assign eff_count = (cnt_ext > XW'(MAX_BOXES)) ? CW'(MAX_BOXES) : CW'(cnt_ext);
	assign slot_ok   = {26'd0, in_slot} < 32'(MAX_BOXES);
	assign rd_addr   = cmd.rd_first ? '0 : idx_q + AW'(1);

	qsbc_ram #(
		.WIDTH($bits(box_t)),
		.DEPTH(MAX_BOXES)
	) u_table (
		.clk  (clk),
		.we   (cmd.load && slot_ok),
		.waddr(AW'(in_slot)),
		.wdata(in_box),
		.raddr(rd_addr),
		.rdata(rd_box)
	);

	assign sw4 = signed'({3'b000, sw_q, 2'b00});
	assign sh4 = signed'({3'b000, sh_q, 2'b00});
	assign lw  = 18'(rd_box.left) + signed'({3'b000, rd_box.width});
	assign bh  = 18'(rd_box.bottom) - signed'({3'b000, rd_box.height});
	assign x0  = PNT_W'(rd_box.left) <<< STEP_SHIFT;
	assign x1  = PNT_W'(lw) <<< STEP_SHIFT;
	assign y1  = PNT_W'(rd_box.bottom) <<< STEP_SHIFT;
	assign y0  = PNT_W'(bh) <<< STEP_SHIFT;

	assign st.count_zero = (eff_count == '0);
	assign st.oob        = (px_q <= 0) || (px_q >= sw4) || (py_q <= 0) || (py_q >= sh4);
	assign st.hit        = (px_q >= x0) && (px_q <= x1) && (py_q >= y0) && (py_q <= y1);
	assign st.last_box   = ((CW'(idx_q) + CW'(1)) == eff_count);
	assign st.last_step  = (step_q == STEP_W'(SUB_STEPS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sw_q    <= SCREEN_W_RST;
			sh_q    <= SCREEN_H_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_OBJECT_COUNT:  count_q <= cfg_wdata[CNT_W-1:0];
				REG_SCREEN_WIDTH:  sw_q    <= cfg_wdata;
				REG_SCREEN_HEIGHT: sh_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_W'(1);
			idx_q  <= '0;
		end else begin
			if (cmd.capture) begin
				step_q <= STEP_W'(1);
			end else if (cmd.step_next) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			px_q <= (sx_w <<< STEP_SHIFT) + ddx;
			py_q <= (sy_w <<< STEP_SHIFT) + ddy;
			dx_q <= ddx;
			dy_q <= ddy;
		end else if (cmd.step_next) begin
			px_q <= px_q + dx_q;
			py_q <= py_q + dy_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_clear_q   <= '0;
			res_outcome_q <= OUT_NONE;
			res_kind_q    <= '0;
			out_clear_q   <= '0;
			out_outcome_q <= OUT_NONE;
			out_kind_q    <= '0;
		end else begin
			if (cmd.set_res) begin
				case (cmd.res_sel)
					RES_OOB: begin
						res_clear_q   <= step_q - STEP_W'(1);
						res_outcome_q <= OUT_OOB;
						res_kind_q    <= '0;
					end
					RES_HIT: begin
						res_clear_q   <= step_q - STEP_W'(1);
						res_outcome_q <= OUT_HIT;
						res_kind_q    <= rd_box.kind;
					end
					default: begin
						res_clear_q   <= STEP_W'(SUB_STEPS);
						res_outcome_q <= OUT_NONE;
						res_kind_q    <= '0;
					end
				endcase
			end
			if (cmd.out_load) begin
				out_clear_q   <= res_clear_q;
				out_outcome_q <= res_outcome_q;
				out_kind_q    <= res_kind_q;
			end
		end
	end

	assign m_tdata = {3'b000, out_kind_q, out_outcome_q, out_clear_q};

	a_kind_only_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(res_outcome_q != OUT_HIT) |-> (res_kind_q == '0))
		else $error("hit kind set without a hit");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != '0) && (step_q <= STEP_W'(SUB_STEPS)))
		else $error("sub-step counter out of range");

	a_hit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.set_res && cmd.res_sel == RES_HIT) |=>
		(res_outcome_q == OUT_HIT) && (res_clear_q < STEP_W'(SUB_STEPS)))
		else $error("hit result recorded wrongly");

endmodule

@@ src/qsbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// qsbc_ctrl
// Controller: handshakes, sub-step and box scan sequencing, output register.
// ----------------------------------------------------------------------------
module qsbc_ctrl
	import qsbc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	input  st_t  st,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.res_sel = RES_EMPTY;
		s_tready    = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser) begin
						cmd.capture = 1'b1;
						if (st.count_zero) begin
							cmd.set_res = 1'b1;
							cmd.res_sel = RES_EMPTY;
							state_d     = S_DONE;
						end else begin
							state_d = S_PROBE;
						end
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			S_PROBE: begin
				if (st.oob) begin
					cmd.set_res = 1'b1;
					cmd.res_sel = RES_OOB;
					state_d     = S_DONE;
				end else begin
					cmd.rd_first = 1'b1;
					cmd.idx_clr  = 1'b1;
					state_d      = S_SCAN;
				end
			end
			S_SCAN: begin
				if (st.hit) begin
					cmd.set_res = 1'b1;
					cmd.res_sel = RES_HIT;
					state_d     = S_DONE;
				end else if (st.last_box) begin
					if (st.last_step) begin
						cmd.set_res = 1'b1;
						cmd.res_sel = RES_CLEAR;
						state_d     = S_DONE;
					end else begin
						cmd.step_next = 1'b1;
						state_d       = S_PROBE;
					end
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign m_tvalid = m_tvalid_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid_q || m_tready))
		else $error("output word overwritten");

	a_query_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser) |=> (state_q == S_PROBE || state_q == S_DONE))
		else $error("query not started");

	a_box_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !s_tuser) |=> (state_q == S_IDLE))
		else $error("box load left idle");

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quarter-step box collision unit.
// Boxes are loaded into the table and swept-point queries are run against
// them. A predictor in the bench walks the four sub-steps and the active
// boxes, and each result word is checked against it field by field. A
// directed pass covers field extremes, box edges, slot priority, screen
// limits and the empty table. Random traffic then runs under several register
// settings, with random gaps on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import qsbc_pkg::*;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam int QUERY_LATENCY = 2 + SUB_STEPS * (MAX_BOXES_DEF + 1);
	localparam int SETTLE_CYCLES = QUERY_LATENCY + 8;
	localparam int HOLD_CYCLES   = 600;
	localparam int LIMIT_CYCLES  = 3000000;
	localparam int RAND_PHASES   = 14;
	localparam int PHASE_ITEMS   = 75;

	typedef struct packed {
		logic [3:0]                pad;
		logic signed [COORD_W-1:0] end_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] start_x;
		logic [KIND_W-1:0]         kind;
		logic [EXT_W-1:0]          height;
		logic [EXT_W-1:0]          width;
		logic signed [COORD_W-1:0] bottom;
		logic signed [COORD_W-1:0] left;
		logic [SLOT_W-1:0]         slot;
	} in_word_t;

	typedef struct packed {
		logic [2:0]        pad;
		logic [KIND_W-1:0] kind;
		logic [OUTC_W-1:0] outcome;
		logic [STEP_W-1:0] clear;
	} res_word_t;

	typedef struct {
		logic [STEP_W-1:0] clear;
		outcome_t          outcome;
		logic [KIND_W-1:0] kind;
	} sweep_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CIDX_W-1:0]     cfg_index;
	logic [CFG_W-1:0]      cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	// bench copy of the table and registers
	logic signed [COORD_W-1:0] box_left_m   [MAX_BOXES_DEF];
	logic signed [COORD_W-1:0] box_bottom_m [MAX_BOXES_DEF];
	logic [EXT_W-1:0]          box_w_m      [MAX_BOXES_DEF];
	logic [EXT_W-1:0]          box_h_m      [MAX_BOXES_DEF];
	logic [KIND_W-1:0]         box_kind_m   [MAX_BOXES_DEF];
	logic [CNT_W-1:0]          active_count;
	logic [SCR_W-1:0]          limit_x;
	logic [SCR_W-1:0]          limit_y;

	sweep_result_t pending_results[$];

	int errors     = 0;
	int n_loads    = 0;
	int n_queries  = 0;
	int n_hits     = 0;
	int n_oob      = 0;
	int n_settings = 0;
	bit burst        = 1'b0;
	bit hold_request = 1'b0;

	quarter_step_box_collision_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #1 clk = ~clk;

	function automatic sweep_result_t predict_sweep(
		logic signed [COORD_W-1:0] sx, logic signed [COORD_W-1:0] sy,
		logic signed [COORD_W-1:0] ex, logic signed [COORD_W-1:0] ey);
		sweep_result_t r;
		longint px, py, lim_x, lim_y, x0, x1, y0, y1;
		int n, k, i;
		r.clear = 3'(SUB_STEPS);
		r.outcome = OUT_NONE;
		r.kind = '0;
		n = (int'(active_count) > MAX_BOXES_DEF) ? MAX_BOXES_DEF : int'(active_count);
		if (n == 0)
			return r;
		lim_x = longint'(limit_x) * SUB_STEPS;
		lim_y = longint'(limit_y) * SUB_STEPS;
		for (k = 1; k <= SUB_STEPS; k++) begin
			px = longint'(sx) * SUB_STEPS + k * (longint'(ex) - longint'(sx));
			py = longint'(sy) * SUB_STEPS + k * (longint'(ey) - longint'(sy));
			// screen limits win over any box
			if (px <= 0 || px >= lim_x || py <= 0 || py >= lim_y) begin
				r.clear = 3'(k - 1);
				r.outcome = OUT_OOB;
				return r;
			end
			for (i = 0; i < n; i++) begin
				x0 = longint'(box_left_m[i]) * SUB_STEPS;
				x1 = (longint'(box_left_m[i]) + longint'(box_w_m[i])) * SUB_STEPS;
				y1 = longint'(box_bottom_m[i]) * SUB_STEPS;
				y0 = (longint'(box_bottom_m[i]) - longint'(box_h_m[i])) * SUB_STEPS;
				if (px >= x0 && px <= x1 && py >= y0 && py <= y1) begin
					r.clear = 3'(k - 1);
					r.outcome = OUT_HIT;
					r.kind = box_kind_m[i];
					return r;
				end
			end
		end
		return r;
	endfunction

	function automatic int draw_gap();
		return burst ? 0 : int'($urandom_range(0, 11));
	endfunction

	function automatic logic signed [COORD_W-1:0] clamp16(int v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return 16'(v);
	endfunction

	function automatic in_word_t rand_word();
		logic [159:0] bits;
		in_word_t w;
		bits = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
		w = bits[IN_DATA_W-1:0];
		w.pad = '0;
		return w;
	endfunction

	function automatic in_word_t make_load_word(int slot);
		in_word_t w;
		w = rand_word();
		w.slot = 6'(slot);
		if ($urandom_range(0, 3) != 0) begin
			w.left   = 16'($urandom_range(0, 10000));
			w.bottom = 16'($urandom_range(200, 7600));
			w.width  = 15'($urandom_range(0, 1500));
			w.height = 15'($urandom_range(0, 1500));
		end
		return w;
	endfunction

	function automatic in_word_t make_query_word(int n);
		in_word_t w;
		int sel, s, x, y;
		w = rand_word();
		sel = $urandom_range(0, 99);
		if (sel < 60 && n > 0) begin
			// land inside a live box, start somewhere nearby
			s = $urandom_range(0, n - 1);
			x = int'(box_left_m[s]) + int'($urandom_range(0, box_w_m[s]));
			y = int'(box_bottom_m[s]) - int'($urandom_range(0, box_h_m[s]));
			w.end_x = clamp16(x);
			w.end_y = clamp16(y);
			w.start_x = clamp16(x + int'($urandom_range(0, 4000)) - 2000);
			w.start_y = clamp16(y + int'($urandom_range(0, 4000)) - 2000);
		end else if (sel < 85) begin
			w.start_x = 16'($urandom_range(0, limit_x));
			w.start_y = 16'($urandom_range(0, limit_y));
			w.end_x   = 16'($urandom_range(0, limit_x));
			w.end_y   = 16'($urandom_range(0, limit_y));
		end
		return w;
	endfunction

	task automatic send_word(input logic mode, input in_word_t w);
		int gap;
		sweep_result_t r;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		s_tuser  <= mode;
		do @(posedge clk); while (!s_tready);
		if (mode == MODE_LOAD) begin
			box_left_m[w.slot]   = w.left;
			box_bottom_m[w.slot] = w.bottom;
			box_w_m[w.slot]      = w.width;
			box_h_m[w.slot]      = w.height;
			box_kind_m[w.slot]   = w.kind;
			n_loads++;
		end else begin
			r = predict_sweep(w.start_x, w.start_y, w.end_x, w.end_y);
			pending_results.push_back(r);
			n_queries++;
			if (r.outcome == OUT_HIT)
				n_hits++;
			if (r.outcome == OUT_OOB)
				n_oob++;
		end
		@(negedge clk);
	endtask

	task automatic load_box(input int slot, input int left, input int bottom,
		input int width, input int height, input int kind);
		in_word_t w;
		w = rand_word();
		w.slot   = 6'(slot);
		w.left   = 16'(left);
		w.bottom = 16'(bottom);
		w.width  = 15'(width);
		w.height = 15'(height);
		w.kind   = 8'(kind);
		send_word(MODE_LOAD, w);
	endtask

	task automatic query(input int sx, input int sy, input int ex, input int ey);
		in_word_t w;
		w = rand_word();
		w.start_x = 16'(sx);
		w.start_y = 16'(sy);
		w.end_x   = 16'(ex);
		w.end_y   = 16'(ey);
		send_word(MODE_QUERY, w);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (idx)
			REG_OBJECT_COUNT:  active_count = val[CNT_W-1:0];
			REG_SCREEN_WIDTH:  limit_x = val[SCR_W-1:0];
			REG_SCREEN_HEIGHT: limit_y = val[SCR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(input int cnt, input int sw, input int sh);
		settle();
		write_reg(REG_OBJECT_COUNT, 15'(cnt));
		write_reg(REG_SCREEN_WIDTH, 15'(sw));
		write_reg(REG_SCREEN_HEIGHT, 15'(sh));
		n_settings++;
	endtask

	// count is 0 out of reset: nothing collides, not even the screen edge
	task automatic test_empty_table();
		query(0, 0, -32768, 32767);
		query(32767, -32768, 32767, 32767);
		query(100, 100, 200, 200);
	endtask

	task automatic test_unused_register();
		settle();
		write_reg(REG_UNUSED, '1);
	endtask

	task automatic test_box_hits();
		load_box(0, 1600, 1600, 800, 800, 8'hA5);
		load_box(1, 1500, 2000, 2000, 2000, 8'h3C);
		load_box(2, -32768, 32767, 32767, 32767, 8'hFF);
		load_box(3, 4000, 4000, 32767, 32767, 8'h5A);
		load_box(63, 32767, -32768, 0, 0, 8'h00);
		settle();
		write_reg(REG_OBJECT_COUNT, 15'd4);
		query(100, 100, 2000, 1200);
		query(2000, 1200, 2000, 1200);
		query(1600, 800, 1600, 800);
		query(2400, 1600, 2400, 1600);
		query(3000, 1800, 3000, 1800);
		query(100, 100, -300, 100);
		query(10000, 6000, 10240, 6000);
		query(3999, 4001, 4003, 3997);
		query(4001, 4001, 3998, 3999);
		query(-32768, -32768, 32767, 32767);
		query(32767, 32767, -32768, -32768);
	endtask

	task automatic test_screen_limits();
		configure(4, 1, 7680);
		query(0, 100, 1, 100);
		configure(4, 10240, 0);
		query(2000, 1200, 2000, 1200);
		configure(4, 32767, 32767);
		query(30000, 30000, 32767, 32767);
		query(32766, 32766, 32767, 1);
	endtask

	task automatic test_output_backpressure();
		int i;
		configure(4, 10240, 7680);
		burst = 1'b1;
		hold_request = 1'b1;
		for (i = 0; i < 20; i++)
			send_word(MODE_QUERY, make_query_word(4));
		burst = 1'b0;
		settle();
	endtask

	task automatic test_random_traffic();
		int slot, p, i, cnt, sw, sh, live;
		for (slot = 0; slot < MAX_BOXES_DEF; slot++)
			send_word(MODE_LOAD, make_load_word(slot));
		for (p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: cnt = 64;
				1: cnt = 127;
				2: cnt = 0;
				3: cnt = 1;
				default: cnt = $urandom_range(1, 127);
			endcase
			sw = (p == 4) ? 32767 : (p == 5) ? 1 :
				($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 32767)) : 10240;
			sh = (p == 6) ? 32767 : (p == 7) ? 1 :
				($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 32767)) : 7680;
			configure(cnt, sw, sh);
			live = (cnt > MAX_BOXES_DEF) ? MAX_BOXES_DEF : cnt;
			burst = (p % 5 == 4);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 4) == 0)
					send_word(MODE_LOAD, make_load_word($urandom_range(0, MAX_BOXES_DEF - 1)));
				else
					send_word(MODE_QUERY, make_query_word(live));
			end
			burst = 1'b0;
		end
	endtask

	initial begin : rx_ready
		int w;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end
			w = draw_gap();
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin : result_check
		res_word_t got;
		sweep_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word, got %h", $time, m_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.clear != want.clear) begin
					$display("%0t: clear_steps expected %0d got %0d", $time, want.clear, got.clear);
					errors++;
				end
				if (got.outcome != want.outcome) begin
					$display("%0t: outcome expected %0d got %0d", $time, want.outcome,
						got.outcome);
					errors++;
				end
				if (got.kind != want.kind) begin
					$display("%0t: hit_kind expected %h got %h", $time, want.kind, got.kind);
					errors++;
				end
				if (got.pad != '0) begin
					$display("%0t: pad bits expected 0 got %h", $time, got.pad);
					errors++;
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			pending_results.size());
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_OBJECT_COUNT;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = MODE_LOAD;
		active_count = '0;
		limit_x = SCREEN_W_RST;
		limit_y = SCREEN_H_RST;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_table();
		test_unused_register();
		test_box_hits();
		test_screen_limits();
		test_output_backpressure();
		test_random_traffic();
		settle();

		$display("ran %0d box loads and %0d queries under %0d register settings",
			n_loads, n_queries, n_settings);
		$display("queries ending in a box hit: %0d, off screen: %0d, mismatches: %0d",
			n_hits, n_oob, errors);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ quarter_step_box_collision_unit.f @@
src/qsbc_pkg.sv
src/qsbc_ram.sv
src/qsbc_dp.sv
src/qsbc_ctrl.sv
src/quarter_step_box_collision_unit.sv
verif/tb_top.sv
